/* hdl/lcbx_pkg.sv */
`timescale 1ns / 1ps
package lcbx_pkg;

  localparam int SAMPLE_BITS       = 24;
  localparam int DEFAULT_MAX_DELAY = 1024;

  localparam int BS_W      = 13;
  localparam int LAT_W     = 10;
  localparam int CD_W      = 12;
  localparam int POS_W     = 12;
  localparam int GAIN_W    = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;

  localparam logic [BS_W-1:0]   BLOCK_MAX     = 13'd4096;
  localparam logic [BS_W-1:0]   BLOCK_RESET   = 13'd512;
  localparam logic [GAIN_W-1:0] GAIN_ONE      = 17'd65536;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LATENCY        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_ENABLE = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] dry_sample;
    logic signed [SAMPLE_BITS-1:0] wet_sample;
    logic                          enable;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic                          wet_used;
    logic                          fading;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic lookup;
    logic step_load;
    logic mix;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

/* hdl/lcbx_div.sv */
`timescale 1ns / 1ps
module lcbx_div
  import lcbx_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [BS_W-1:0]   divisor,
  output logic              busy,
  output logic [GAIN_W-1:0] quotient
);

  localparam int CNT_W = $clog2(GAIN_W + 1);

  logic [BS_W-1:0]  dvs;
  logic [BS_W-1:0]  rem;
  logic [CNT_W-1:0] cnt;
  logic [BS_W:0]    trial;
  logic             fits;

  assign trial = {rem, quotient[GAIN_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(GAIN_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs      <= divisor;
      rem      <= '0;
      quotient <= GAIN_ONE;
    end else if (busy) begin
      if (fits) begin
        rem      <= BS_W'(trial - {1'b0, dvs});
        quotient <= {quotient[GAIN_W-2:0], 1'b1};
      end else begin
        rem      <= trial[BS_W-1:0];
        quotient <= {quotient[GAIN_W-2:0], 1'b0};
      end
    end
  end

endmodule

/* hdl/lcbx_ctrl.sv */
`timescale 1ns / 1ps
module lcbx_ctrl
  import lcbx_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOOKUP = 3'd1;
  localparam logic [2:0] ST_DIVIDE = 3'd2;
  localparam logic [2:0] ST_MIX    = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = state != ST_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (!status.div_busy) begin
          cmd.step_load = 1'b1;
          state_next    = ST_MIX;
        end
      end
      ST_MIX: begin
        cmd.mix    = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hdl/lcbx_dp.sv */
`timescale 1ns / 1ps
module lcbx_dp
  import lcbx_pkg::*;
#(
  parameter int MAX_DELAY = DEFAULT_MAX_DELAY
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  in_item_t             in_item,
  input  cmd_t                 cmd,
  output status_t              status,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item
);

  localparam int PTR_W   = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int FILL_W  = $clog2(MAX_DELAY + 1);
  localparam int CMP_W   = ((FILL_W > LAT_W) ? FILL_W : LAT_W) + 1;
  localparam int LAT_MAX = MAX_DELAY - 1;
  localparam int PROD_W  = SAMPLE_BITS + GAIN_W + 2;
  localparam int SUM_W   = PROD_W + 1;
  localparam int SH_W    = SUM_W - 16;

  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_ON   = 2'd1;
  localparam logic [1:0] MODE_FADE = 2'd2;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [BS_W-1:0]  reg_block_size;
  logic [LAT_W-1:0] reg_latency;

  logic signed [SAMPLE_BITS-1:0] store [MAX_DELAY];
  logic signed [SAMPLE_BITS-1:0] mem_q;
  logic [PTR_W-1:0]  wr_ptr;
  logic [FILL_W-1:0] fill;
  logic              dly_valid;

  in_item_t                in_q;
  logic                    previous_enable;
  logic                    block_enable;
  logic signed [CD_W-1:0]  countdown;
  logic [POS_W-1:0]        position;
  logic [BS_W-1:0]         fade_start;
  logic [GAIN_W-1:0]       ramp_gain;
  logic [GAIN_W-1:0]       ramp_step;
  logic [1:0]              block_mode;
  logic [BS_W-1:0]         block_length;
  logic                    step_pending;
  logic signed [PROD_W-1:0] prod;

  logic [LAT_W-1:0]  lat_eff;
  logic [PTR_W-1:0]  lat_p;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W-1:0]  wr_ptr_inc;

  logic [BS_W-1:0]         n_eff;
  logic signed [CD_W-1:0]  cd_eff;
  logic signed [CD_W+1:0]  cd_diff;
  logic [BS_W-1:0]         cd_pos;
  logic signed [CD_W-1:0]  cd_new;
  logic [BS_W-1:0]         start_pos;
  logic [BS_W-1:0]         fade_len;
  logic                    changed;
  logic                    div_start;
  logic                    div_busy;
  logic [GAIN_W-1:0]       div_q;

  logic signed [SAMPLE_BITS-1:0] dly;
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [SUM_W-1:0]       mix_sum;
  logic signed [SH_W-1:0]        mix_sh;
  logic signed [SAMPLE_BITS-1:0] mix_sat;
  logic [GAIN_W:0]               gain_up;
  logic [BS_W-1:0]               pos_inc;
  out_item_t                     result;

  assign lat_eff    = (32'(reg_latency) > LAT_MAX) ? LAT_W'(LAT_MAX) : reg_latency;
  assign lat_p      = PTR_W'(lat_eff);
  assign rd_ptr     = (wr_ptr >= lat_p) ? wr_ptr - lat_p : PTR_W'(MAX_DELAY) + wr_ptr - lat_p;
  assign wr_ptr_inc = (wr_ptr == PTR_W'(LAT_MAX)) ? '0 : wr_ptr + 1'b1;

  always_comb begin
    if (reg_block_size == '0) begin
      n_eff = BS_W'(1);
    end else if (reg_block_size > BLOCK_MAX) begin
      n_eff = BLOCK_MAX;
    end else begin
      n_eff = reg_block_size;
    end
    cd_eff    = (in_q.enable && countdown < 0) ? $signed({2'b00, lat_eff}) : countdown;
    cd_diff   = {{2{cd_eff[CD_W-1]}}, cd_eff} - $signed({1'b0, n_eff});
    cd_pos    = BS_W'($unsigned(cd_eff));
    if (cd_eff <= 0) begin
      cd_new    = '1;
      start_pos = '0;
    end else if (cd_pos < (n_eff >> 2)) begin
      cd_new    = '1;
      start_pos = cd_pos;
    end else begin
      cd_new    = (cd_diff < 0) ? '0 : CD_W'(cd_diff);
      start_pos = n_eff;
    end
    fade_len  = n_eff - start_pos;
    changed   = in_q.enable != previous_enable;
    div_start = cmd.lookup && position == '0 && changed && fade_len != '0;
  end

  lcbx_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (fade_len),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.lookup && lat_eff != '0) begin
      store[wr_ptr] <= in_q.dry_sample;
      mem_q         <= store[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_q <= in_item;
    end
    if (cmd.lookup) begin
      dly_valid <= CMP_W'(fill) >= CMP_W'(lat_eff);
    end
  end

  always_comb begin
    if (lat_eff == '0) begin
      dly = in_q.dry_sample;
    end else if (dly_valid) begin
      dly = mem_q;
    end else begin
      dly = '0;
    end
    diff    = {in_q.wet_sample[SAMPLE_BITS-1], in_q.wet_sample}
            - {dly[SAMPLE_BITS-1], dly};
    mix_sum = $signed({{(SUM_W-SAMPLE_BITS-16){dly[SAMPLE_BITS-1]}}, dly, 16'd0})
            + {prod[PROD_W-1], prod} + SUM_W'(32768);
    mix_sh  = mix_sum[SUM_W-1:16];
    if (&mix_sh[SH_W-1:SAMPLE_BITS-1] || ~|mix_sh[SH_W-1:SAMPLE_BITS-1]) begin
      mix_sat = mix_sh[SAMPLE_BITS-1:0];
    end else begin
      mix_sat = mix_sh[SH_W-1] ? SAMPLE_LO : SAMPLE_HI;
    end
    gain_up = {1'b0, ramp_gain} + {1'b0, ramp_step};
    pos_inc = {1'b0, position} + 1'b1;
    result  = '0;
    if (block_mode == MODE_OFF) begin
      result.out_sample = dly;
    end else if (block_mode == MODE_ON) begin
      result.out_sample = in_q.wet_sample;
      result.wet_used   = 1'b1;
    end else begin
      result.out_sample = mix_sat;
      result.wet_used   = 1'b1;
      result.fading     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mix) begin
      prod <= PROD_W'(diff) * PROD_W'($signed({1'b0, ramp_gain}));
    end
    if (cmd.finish) begin
      out_item <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_block_size  <= BLOCK_RESET;
      reg_latency     <= '0;
      previous_enable <= 1'b1;
      block_enable    <= 1'b0;
      countdown       <= '1;
      position        <= '0;
      fade_start      <= '0;
      ramp_gain       <= '0;
      ramp_step       <= '0;
      block_mode      <= MODE_OFF;
      block_length    <= BLOCK_RESET;
      step_pending    <= 1'b0;
      wr_ptr          <= '0;
      fill            <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BLOCK_SIZE: begin
            reg_block_size <= cfg_data[BS_W-1:0];
          end
          CFG_LATENCY: begin
            reg_latency <= cfg_data[LAT_W-1:0];
            if (cfg_data[LAT_W-1:0] == '0) begin
              wr_ptr <= '0;
              fill   <= '0;
            end
          end
          CFG_INITIAL_ENABLE: begin
            previous_enable <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end

      if (cmd.lookup) begin
        if (lat_eff != '0) begin
          wr_ptr <= wr_ptr_inc;
          if (fill != FILL_W'(MAX_DELAY)) begin
            fill <= fill + 1'b1;
          end
        end
        if (position == '0) begin
          block_length <= n_eff;
          block_enable <= in_q.enable;
          if (!changed) begin
            step_pending <= 1'b0;
            block_mode   <= in_q.enable ? MODE_ON : MODE_OFF;
            if (in_q.enable) begin
              countdown <= '0;
            end
          end else begin
            countdown    <= cd_new;
            fade_start   <= start_pos;
            ramp_gain    <= in_q.enable ? '0 : GAIN_ONE;
            block_mode   <= MODE_FADE;
            step_pending <= fade_len != '0;
            if (fade_len == '0) begin
              ramp_step <= '0;
            end else begin
              previous_enable <= in_q.enable;
            end
          end
        end
      end

      if (cmd.step_load && step_pending) begin
        ramp_step    <= div_q;
        step_pending <= 1'b0;
      end

      if (cmd.mix && block_mode == MODE_FADE && {1'b0, position} >= fade_start) begin
        if (block_enable) begin
          ramp_gain <= (gain_up > {1'b0, GAIN_ONE}) ? GAIN_ONE : gain_up[GAIN_W-1:0];
        end else begin
          ramp_gain <= (ramp_gain > ramp_step) ? ramp_gain - ramp_step : '0;
        end
      end

      if (cmd.finish) begin
        position  <= (pos_inc >= block_length) ? '0 : pos_inc[POS_W-1:0];
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.div_busy = div_busy;
  assign status.out_free = !out_valid || !out_stall;

endmodule

/* hdl/latency_compensated_bypass_crossfade_core.sv */
`timescale 1ns / 1ps
// Sequence: after the input transfer the controller steps LOOKUP, DIVIDE, MIX and
//   FINISH, registering out_valid; DIVIDE waits on the step divider when a block
//   starts a crossfade, and FINISH waits while the output is stalled.
// Flow: a new item waits until FINISH is done; the divider gives one bit per cycle.
// Reset: synchronous, active high; registers return to defaults, delay store is
//   emptied by a fill count at once, so no clearing pass is needed.
module latency_compensated_bypass_crossfade_core
  import lcbx_pkg::*;
#(
  parameter int MAX_DELAY = DEFAULT_MAX_DELAY
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  lcbx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lcbx_dp #(
    .MAX_DELAY (MAX_DELAY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

`ifndef NO_ASSERTIONS
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transfer taken while an item is in flight");

  a_mix_after_divide: assert property (@(posedge clk) disable iff (rst)
    cmd.mix |-> !status.div_busy)
    else $error("mix issued while step divider busy");

  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.finish))
    else $error("result raised without a finish command");
`endif

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
module tb;
  import lcbx_pkg::*;

  typedef enum logic [1:0] {
    MODE_BYPASS,
    MODE_EFFECT,
    MODE_FADE
  } mix_mode_t;

  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam int unsigned UNITY = 32'(GAIN_ONE);
  localparam int unsigned DEPTH = DEFAULT_MAX_DELAY;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_item = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_BLOCK_SIZE;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  latency_compensated_bypass_crossfade_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // crossfade state as the block should hold it
  logic signed [SAMPLE_BITS-1:0] delay_line [DEPTH];
  int unsigned wr_ptr;
  int unsigned size_reg;
  int unsigned lat_reg;
  bit          prev_en;
  bit          blk_en;
  int          countdown;
  int unsigned pos;
  int unsigned fade_pos;
  int unsigned gain;
  int unsigned gain_step;
  int unsigned blk_len;
  mix_mode_t   mode;

  in_item_t  sample_q[$];
  out_item_t expected_out_q[$];
  out_item_t want;
  int        samples_queued = 0;
  int        results_checked = 0;
  int        fade_results = 0;
  int        settings_done = 0;
  int        errors = 0;
  bit        steady_flow = 1'b0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        stall_left = 0;
  int        open_left = 0;

  function automatic void clear_delay_line();
    for (int i = 0; i < DEPTH; i++) delay_line[i] = '0;
    wr_ptr = 0;
  endfunction

  function automatic void state_reset();
    clear_delay_line();
    size_reg = 32'(BLOCK_RESET);
    lat_reg = 0;
    prev_en = 1'b1;
    blk_en = 1'b0;
    countdown = -1;
    pos = 0;
    fade_pos = 0;
    gain = 0;
    gain_step = 0;
    mode = MODE_BYPASS;
    blk_len = 32'(BLOCK_RESET);
  endfunction

  function automatic void config_update(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    case (idx)
      CFG_BLOCK_SIZE: begin
        size_reg = 32'(val);
      end
      CFG_LATENCY: begin
        lat_reg = 32'(val[LAT_W-1:0]);
        if (lat_reg == 0) clear_delay_line();
      end
      CFG_INITIAL_ENABLE: begin
        prev_en = val[0];
      end
      default: begin
      end
    endcase
  endfunction

  function automatic longint blend(longint wet, longint dly, int unsigned g);
    longint acc;
    acc = wet * longint'(g) + dly * longint'(UNITY - g) + 64'sd32768;
    acc = acc >>> 16;
    if (acc > longint'(SMAX)) acc = longint'(SMAX);
    if (acc < longint'(SMIN)) acc = longint'(SMIN);
    return acc;
  endfunction

  function automatic out_item_t crossfade_predict(in_item_t it);
    int unsigned n;
    int unsigned d;
    int unsigned wr;
    int unsigned rd;
    int unsigned start;
    int unsigned len;
    int          left;
    longint      dry;
    longint      wet;
    longint      dly;
    out_item_t   o;
    dry = longint'($signed(it.dry_sample));
    wet = longint'($signed(it.wet_sample));
    d = (lat_reg > DEPTH - 1) ? DEPTH - 1 : lat_reg;
    if (pos == 0) begin
      n = size_reg;
      if (n < 1) n = 1;
      if (n > 32'(BLOCK_MAX)) n = 32'(BLOCK_MAX);
      blk_len = n;
      blk_en = it.enable;
      if (blk_en == prev_en) begin
        mode = blk_en ? MODE_EFFECT : MODE_BYPASS;
        if (blk_en) countdown = 0;
      end else begin
        if (blk_en && countdown < 0) countdown = int'(d);
        if (countdown <= 0) begin
          countdown = -1;
          start = 0;
        end else if (countdown < int'(n / 4)) begin
          start = countdown;
          countdown = -1;
        end else begin
          left = countdown - int'(n);
          countdown = (left < 0) ? 0 : left;
          start = n;
        end
        fade_pos = start;
        gain = blk_en ? 0 : UNITY;
        len = n - start;
        gain_step = (len != 0) ? UNITY / len : 0;
        if (start < n) prev_en = blk_en;
        mode = MODE_FADE;
      end
    end
    if (d == 0) begin
      dly = dry;
    end else begin
      wr = wr_ptr % DEPTH;
      rd = (wr + DEPTH - d) % DEPTH;
      delay_line[wr] = it.dry_sample;
      dly = longint'(delay_line[rd]);
      wr_ptr = (wr + 1) % DEPTH;
    end
    case (mode)
      MODE_BYPASS: begin
        o.out_sample = dly[SAMPLE_BITS-1:0];
        o.wet_used = 1'b0;
        o.fading = 1'b0;
      end
      MODE_EFFECT: begin
        o.out_sample = wet[SAMPLE_BITS-1:0];
        o.wet_used = 1'b1;
        o.fading = 1'b0;
      end
      default: begin
        o.out_sample = SAMPLE_BITS'(blend(wet, dly, gain));
        o.wet_used = 1'b1;
        o.fading = 1'b1;
        if (pos >= fade_pos) begin
          if (blk_en) gain = (gain + gain_step > UNITY) ? UNITY : gain + gain_step;
          else gain = (gain > gain_step) ? gain - gain_step : 0;
        end
      end
    endcase
    pos++;
    if (pos >= blk_len) pos = 0;
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_out_q.push_back(crossfade_predict(in_item));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 || sample_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          in_item <= sample_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = steady_flow ? 0 : $urandom_range(1, 9);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_out_q.size() == 0) begin
          $display("%0t: result with nothing expected: sample %h wet_used %b fading %b",
                   $time, out_item.out_sample, out_item.wet_used, out_item.fading);
          errors++;
        end else begin
          want = expected_out_q.pop_front();
          results_checked++;
          if (out_item.fading === 1'b1) fade_results++;
          if (out_item.out_sample !== want.out_sample) begin
            $display("%0t: out_sample expected %h got %h", $time, want.out_sample,
                     out_item.out_sample);
            errors++;
          end
          if (out_item.wet_used !== want.wet_used) begin
            $display("%0t: wet_used expected %b got %b", $time, want.wet_used,
                     out_item.wet_used);
            errors++;
          end
          if (out_item.fading !== want.fading) begin
            $display("%0t: fading expected %b got %b", $time, want.fading, out_item.fading);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (open_left > 0) begin
        open_left--;
      end else begin
        open_left = $urandom_range(1, 12);
        stall_left = steady_flow ? 0 : $urandom_range(1, 9);
      end
      out_stall <= (stall_left > 0);
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return SMAX;
      1: return SMIN;
      2: return '0;
      3: return '1;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic queue_sample(input logic signed [SAMPLE_BITS-1:0] dry,
                              input logic signed [SAMPLE_BITS-1:0] wet, input logic en);
    in_item_t it;
    it.dry_sample = dry;
    it.wet_sample = wet;
    it.enable = en;
    sample_q.push_back(it);
    samples_queued++;
  endtask

  task automatic drain();
    while (results_checked != samples_queued) @(posedge clk);
  endtask

  task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DAT_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    config_update(idx, CFG_DAT_W'(val));
  endtask

  // hold valid across back-to-back writes, drop it once at the end
  task automatic write_regs(input int unsigned bs, input int unsigned lat,
                            input bit init_en, input bit with_init);
    write_one(CFG_BLOCK_SIZE, bs);
    write_one(CFG_LATENCY, lat);
    if (with_init) write_one(CFG_INITIAL_ENABLE, init_en);
    cfg_valid <= 1'b0;
    settings_done++;
  endtask

  task automatic random_phase(input int count);
    int unsigned bs;
    int unsigned lat;
    bit          en;
    case ($urandom_range(0, 9))
      0: bs = 0;
      1: bs = 1;
      2: bs = $urandom_range(65, 160);
      default: bs = $urandom_range(2, 40);
    endcase
    case ($urandom_range(0, 3))
      0: lat = 0;
      1: lat = $urandom_range(13, 1023);
      default: lat = $urandom_range(1, 12);
    endcase
    steady_flow = ($urandom_range(0, 4) == 0);
    write_regs(bs, lat, 1'($urandom_range(0, 1)), $urandom_range(0, 2) == 0);
    en = 1'($urandom_range(0, 1));
    repeat (count) begin
      if ($urandom_range(0, 5) == 0) en = !en;
      queue_sample(pick_sample(), pick_sample(), en);
    end
    drain();
  endtask

  initial begin
    int unsigned fill;
    state_reset();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_regs(2, 0, 1'b0, 1'b1);
    queue_sample(SMAX, SMIN, 1'b0);
    queue_sample(SMIN, SMAX, 1'b0);
    queue_sample(SMAX, SMIN, 1'b1);
    queue_sample(SMIN, SMAX, 1'b1);
    queue_sample('1, SMAX, 1'b0);
    queue_sample(24'sd1, SMIN, 1'b0);
    drain();

    write_regs(0, 3, 1'b0, 1'b0);
    repeat (5) queue_sample(pick_sample(), pick_sample(), 1'b1);
    drain();

    write_regs(8, 1, 1'b0, 1'b0);
    repeat (8) queue_sample(pick_sample(), pick_sample(), 1'b0);
    repeat (8) queue_sample(pick_sample(), pick_sample(), 1'b1);
    drain();

    repeat (6) random_phase($urandom_range(60, 100));

    // longest block with the deepest delay, aligned to a block start
    steady_flow = 1'b0;
    write_regs(8191, 1023, 1'b0, 1'b1);
    fill = (pos == 0) ? 0 : blk_len - pos;
    repeat (fill) queue_sample(pick_sample(), pick_sample(), 1'b0);
    repeat (600) queue_sample(pick_sample(), pick_sample(), 1'b1);
    drain();

    repeat (40) @(posedge clk);
    $display("run covered %0d samples over %0d register settings, %0d in crossfade blocks",
             results_checked, settings_done, fade_results);
    if (errors == 0 && expected_out_q.size() == 0) begin
      $display("PASS latency_compensated_bypass_crossfade_core");
    end else begin
      $display("FAIL latency_compensated_bypass_crossfade_core");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", samples_queued - results_checked);
    $display("FAIL latency_compensated_bypass_crossfade_core");
    $finish;
  end

endmodule
